@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/kmae_pkg.sv @@
`timescale 1ns / 1ps
package kmae_pkg;

  localparam int TableEntries  = 64;
  localparam int MaxKeyBytes   = 8;
  localparam int MaxValueBytes = 8;

  typedef enum logic [2:0] {
    ACT_NOP    = 3'd0,
    ACT_READ   = 3'd1,
    ACT_WRITE  = 3'd2,
    ACT_INSERT = 3'd3,
    ACT_UPDATE = 3'd4,
    ACT_REMOVE = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_OUT
  } state_t;

  localparam logic [0:0] REG_KEY_BYTES   = 1'd0;
  localparam logic [0:0] REG_VALUE_BYTES = 1'd1;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic exec;
    logic out_done;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_last;
  } dp_status_t;

  // Mask of the low n bytes of a 64-bit word.
  function automatic logic [63:0] low_bytes_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < n) m[8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

  function automatic logic [3:0] clamp_size(input logic [3:0] v, input logic [3:0] hi);
    logic [3:0] r;
    if (v == 4'd0) r = 4'd1;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

endpackage

@@ design/keyed_map_access_engine_top.sv @@
`timescale 1ns / 1ps
// Keyed map access engine: a key/value table of TABLE_ENTRIES slots.
// Requests enter on the input channel (in_valid, in_stall) with the action,
// key, offset, count, write data and byte mask. One result per request
// leaves on the output channel (out_valid, out_stall).
// The key memory is scanned one slot per cycle to find the lowest matching and
// the lowest free slot, then the execute state performs the access and the
// result is registered for the output channel. One request is in flight at a
// time: no new request is taken until the result has been delivered.
// While the receiver stalls the result stays on the ports and no new request
// is taken. Reset empties the table (valid bits cleared) and sets the key
// and value byte counts to 8. The APB port writes the key byte count at
// address 0 and the value byte count at address 4; writes must happen only
// while idle, and the block itself does not enforce this.
module keyed_map_access_engine_top #(
  parameter int TABLE_ENTRIES = kmae_pkg::TableEntries
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:2]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [63:0] lookup_key,
  input  logic [3:0]  key_len,
  input  logic [3:0]  byte_offset,
  input  logic [3:0]  byte_count,
  input  logic [63:0] write_data,
  input  logic [7:0]  byte_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] read_data,
  output logic [3:0]  result_length,
  output logic        removed,
  output logic        table_full
);
  import kmae_pkg::*;
  `include "assert_macros.svh"

  logic [3:0] key_bytes, value_bytes, ks, vs;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign pready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes <= 4'd8;
      value_bytes <= 4'd8;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_KEY_BYTES:   key_bytes <= pwdata[3:0];
        REG_VALUE_BYTES: value_bytes <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  assign prdata = {28'd0, paddr[2] ? value_bytes : key_bytes};
  assign ks = clamp_size(key_bytes, 4'(MaxKeyBytes));
  assign vs = clamp_size(value_bytes, 4'(MaxValueBytes));

  kmae_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
  );

  kmae_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .ks(ks), .vs(vs),
    .action(action), .lookup_key(lookup_key), .key_len(key_len),
    .byte_offset(byte_offset), .byte_count(byte_count),
    .write_data(write_data), .byte_mask(byte_mask),
    .read_data(read_data), .result_length(result_length),
    .removed(removed), .table_full(table_full)
  );

  // A request is never taken while a result is pending.
  `ASSERT_IMPLY(a_no_accept_busy, clk, rst, out_valid, in_stall)
  // A remove never reports a length or a full table.
  `ASSERT_IMPLY(a_flags_excl, clk, rst, out_valid && removed,
                !table_full && result_length == 4'd0)
  // After a delivered result the block is ready again.
  `ASSERT_NEXT(a_ready_after, clk, rst, out_valid && !out_stall, !in_stall)
endmodule

@@ design/kmae_ctrl.sv @@
`timescale 1ns / 1ps
module kmae_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  logic                    out_stall,
  input  kmae_pkg::dp_status_t    status,
  output kmae_pkg::ctrl_cmd_t     cmd
);
  import kmae_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.scan_start = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.out_done = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

@@ design/kmae_datapath.sv @@
`timescale 1ns / 1ps
module kmae_datapath #(
  parameter int TABLE_ENTRIES = kmae_pkg::TableEntries
) (
  input  logic                 clk,
  input  logic                 rst,
  input  kmae_pkg::ctrl_cmd_t  cmd,
  output kmae_pkg::dp_status_t status,
  input  logic [3:0]           ks,
  input  logic [3:0]           vs,
  input  logic [2:0]           action,
  input  logic [63:0]          lookup_key,
  input  logic [3:0]           key_len,
  input  logic [3:0]           byte_offset,
  input  logic [3:0]           byte_count,
  input  logic [63:0]          write_data,
  input  logic [7:0]           byte_mask,
  output logic [63:0]          read_data,
  output logic [3:0]           result_length,
  output logic                 removed,
  output logic                 table_full
);
  import kmae_pkg::*;

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Table storage; keys and values live in memories, valid bits in flops.
  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [63:0] key_mem [TABLE_ENTRIES];
  logic [63:0] val_mem [TABLE_ENTRIES];

  // Captured transaction.
  logic [2:0]  r_act;
  logic [63:0] r_key, r_wdata, kmask;
  logic [3:0]  r_klen, r_off, r_cnt;
  logic [7:0]  r_mask;

  // Scan state.
  logic [IdxW-1:0] scan_idx, rd_idx;
  logic            scan_run, rd_vld, rd_was_valid;
  logic [63:0]     rd_key;
  logic            found, free_ok, scan_done;
  logic [IdxW-1:0] found_slot, free_slot;
  logic [63:0]     found_val;

  assign status.scan_last = scan_done;

  // Capture the request.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_act   <= action;
      r_key   <= lookup_key & low_bytes_mask(ks);
      kmask   <= low_bytes_mask(ks);
      r_klen  <= key_len;
      r_off   <= byte_offset;
      r_cnt   <= byte_count;
      r_wdata <= write_data;
      r_mask  <= byte_mask;
    end
  end

  // Registered key memory read feeding the match compare.
  always_ff @(posedge clk) begin
    rd_key <= key_mem[scan_idx];
    rd_idx <= scan_idx;
    rd_was_valid <= entry_valid[scan_idx];
  end

  // Sequential scan in slot order: lowest match and lowest free slot.
  // rd_vld marks that the registered read holds a slot of this scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_run <= 1'b0;
      rd_vld <= 1'b0;
      scan_done <= 1'b0;
      found <= 1'b0;
      free_ok <= 1'b0;
      scan_idx <= '0;
    end else if (cmd.scan_start) begin
      scan_idx <= '0;
      scan_run <= 1'b1;
      rd_vld <= 1'b0;
      scan_done <= 1'b0;
      found <= 1'b0;
      free_ok <= 1'b0;
    end else if (cmd.scan_step) begin
      if (rd_vld) begin
        if (rd_was_valid && ((rd_key & kmask) == r_key) && !found) begin
          found <= 1'b1;
          found_slot <= rd_idx;
        end
        if (!rd_was_valid && !free_ok) begin
          free_ok <= 1'b1;
          free_slot <= rd_idx;
        end
      end
      rd_vld <= scan_run;
      scan_done <= rd_vld && !scan_run;
      if (scan_run) begin
        if (scan_idx == IdxW'(TABLE_ENTRIES - 1)) scan_run <= 1'b0;
        else scan_idx <= scan_idx + IdxW'(1);
      end
    end else begin
      scan_done <= 1'b0;
    end
  end

  // Value read of the matching slot, valid in the execute cycle.
  always_ff @(posedge clk) begin
    found_val <= val_mem[found_slot];
  end

  // Execute: compute the result and update the table.
  logic        act_ok, fit, wr_ok, mk_new, do_wr;
  logic [3:0]  rlen_c;
  logic [4:0]  span, lenc;
  logic [63:0] rdat_c, base, newv;
  logic [IdxW-1:0] wslot;

  always_comb begin
    act_ok = (r_act >= 3'(ACT_READ)) && (r_act <= 3'(ACT_REMOVE)) && (r_klen == ks);
    lenc = '0;
    rdat_c = '0;
    if (found && (r_off < vs)) begin
      lenc = 5'(vs - r_off);
      if ({1'b0, r_cnt} < lenc) lenc = {1'b0, r_cnt};
      rdat_c = (found_val >> {r_off, 3'b000}) & low_bytes_mask(lenc[3:0]);
    end
    span = {1'b0, r_off} + {1'b0, r_cnt};
    fit = span <= {1'b0, vs};
    wr_ok = act_ok && ((r_act == 3'(ACT_WRITE)) || (r_act == 3'(ACT_INSERT)) ||
            (r_act == 3'(ACT_UPDATE))) && fit &&
            !((r_act == 3'(ACT_UPDATE)) && !found) &&
            !((r_act == 3'(ACT_INSERT)) && found);
    mk_new = wr_ok && !found;
    do_wr = wr_ok && (found || free_ok);
    wslot = found ? found_slot : free_slot;
    base = found ? found_val : 64'd0;
    newv = base;
    for (int b = 0; b < 8; b++) begin
      if ((4'(b) < r_cnt) && r_mask[b] && (r_off + 4'(b) < 4'd8))
        newv[8*(r_off + 4'(b)) +: 8] = r_wdata[8*b +: 8];
    end
    rlen_c = 4'd0;
    if (act_ok && r_act == 3'(ACT_READ)) rlen_c = lenc[3:0];
    else if (do_wr) rlen_c = r_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.exec) begin
      if (act_ok && r_act == 3'(ACT_REMOVE) && found) entry_valid[found_slot] <= 1'b0;
      if (do_wr && !found) entry_valid[wslot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && do_wr) begin
      val_mem[wslot] <= newv;
      if (!found) key_mem[wslot] <= r_key;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      read_data     <= act_ok ? rdat_c : 64'd0;
      result_length <= rlen_c;
      removed       <= act_ok && r_act == 3'(ACT_REMOVE) && found;
      table_full    <= mk_new && !free_ok;
    end
  end
endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import kmae_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:2]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid, in_stall;
  logic [2:0]  action;
  logic [63:0] lookup_key;
  logic [3:0]  key_len, byte_offset, byte_count;
  logic [63:0] write_data;
  logic [7:0]  byte_mask;
  logic        out_valid, out_stall;
  logic [63:0] read_data;
  logic [3:0]  result_length;
  logic        removed, table_full;

  keyed_map_access_engine_top uut (.*);

  // Expected result of one access.
  typedef struct packed {
    logic [63:0] rdata;
    logic [3:0]  rlen;
    logic        rem;
    logic        full;
  } access_result_t;

  access_result_t pending_results[$];
  int  errors = 0;
  longint cycles = 0;
  bit  idle_enable = 1;
  bit  long_hold = 0;

  // Shadow copy of the table and the configuration.
  logic [3:0]  cfg_key_bytes, cfg_value_bytes;
  logic        shadow_valid[TableEntries];
  logic [63:0] shadow_key[TableEntries];
  logic [63:0] shadow_value[TableEntries];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Cycle limit for the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("[keyed_map_access_engine_top] ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] byte_lanes(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) if (b < n) m[8*b +: 8] = 8'hFF;
    return m;
  endfunction

  function automatic logic [3:0] saturate(input logic [3:0] v);
    if (v == 0) return 4'd1;
    if (v > 8) return 4'd8;
    return v;
  endfunction

  // Computes the result of one access and updates the shadow table.
  function automatic access_result_t predict_access(
      input logic [2:0] act, input logic [63:0] key_in, input logic [3:0] klen,
      input logic [3:0] off, input logic [3:0] cnt, input logic [63:0] wdata,
      input logic [7:0] bmask);
    access_result_t r;
    logic [3:0] ks, vs, len;
    logic [63:0] kmask, key, v;
    bit found, ok;
    int slot;
    r = '0;
    ks = saturate(cfg_key_bytes);
    vs = saturate(cfg_value_bytes);
    kmask = byte_lanes(ks);
    key = key_in & kmask;
    found = 0;
    slot = 0;
    len = 0;
    if (act == ACT_NOP || act > ACT_REMOVE || klen != ks) return r;
    for (int i = 0; i < TableEntries; i++)
      if (!found && shadow_valid[i] && (shadow_key[i] & kmask) == key) begin
        found = 1;
        slot = i;
      end
    if (found && off < vs) begin
      len = vs - off;
      if (cnt < len) len = cnt;
      r.rdata = (shadow_value[slot] >> (8 * off)) & byte_lanes(len);
    end
    if (act == ACT_READ) begin
      r.rlen = len;
    end else if (act == ACT_REMOVE) begin
      if (found) begin
        shadow_valid[slot] = 0;
        r.rem = 1;
      end
    end else if (5'(off) + 5'(cnt) <= 5'(vs) && !(act == ACT_UPDATE && !found)
                 && !(act == ACT_INSERT && found)) begin
      ok = 1;
      if (!found) begin
        ok = 0;
        for (int i = 0; i < TableEntries; i++)
          if (!ok && !shadow_valid[i]) begin
            slot = i;
            ok = 1;
          end
        if (ok) begin
          shadow_valid[slot] = 1;
          shadow_key[slot] = key;
          shadow_value[slot] = '0;
        end else begin
          r.full = 1;
        end
      end
      if (ok) begin
        v = shadow_value[slot];
        for (int b = 0; b < 8; b++)
          if (b < cnt && bmask[b]) v[8*(off+b) +: 8] = wdata[8*b +: 8];
        shadow_value[slot] = v;
        r.rlen = cnt;
      end
    end
    return r;
  endfunction

  // Sends one transaction and records its expected result. Valid stays up
  // after acceptance until the next transaction or a drain replaces it.
  task automatic send_access(input logic [2:0] act, input logic [63:0] key,
      input logic [3:0] klen, input logic [3:0] off, input logic [3:0] cnt,
      input logic [63:0] wdata, input logic [7:0] bmask);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1;
    action <= act;
    lookup_key <= key;
    key_len <= klen;
    byte_offset <= off;
    byte_count <= cnt;
    write_data <= wdata;
    byte_mask <= bmask;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_access(act, key, klen, off, cnt, wdata, bmask));
  endtask

  // Checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    access_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h %0d %b %b", $time,
                 read_data, result_length, removed, table_full);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (read_data !== e.rdata) begin
          $display("%0t read_data expected %h actual %h", $time, e.rdata, read_data);
          errors++;
        end
        if (result_length !== e.rlen) begin
          $display("%0t result_length expected %0d actual %0d", $time, e.rlen,
                   result_length);
          errors++;
        end
        if (removed !== e.rem) begin
          $display("%0t removed expected %b actual %b", $time, e.rem, removed);
          errors++;
        end
        if (table_full !== e.full) begin
          $display("%0t table_full expected %b actual %b", $time, e.full, table_full);
          errors++;
        end
      end
    end
  end

  // Receiver stalls: random bursts, plus one long hold-off.
  initial begin
    out_stall <= 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1;
        repeat (600) @(posedge clk);
        out_stall <= 0;
        long_hold = 0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic drain;
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TableEntries + 10) @(posedge clk);
  endtask

  // Writes one register through the APB port while the block is idle.
  task automatic write_register(input logic [0:0] index, input logic [3:0] value);
    drain();
    psel <= 1;
    pwrite <= 1;
    paddr <= index;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (index == REG_KEY_BYTES) cfg_key_bytes = value;
    else cfg_value_bytes = value;
  endtask

  function automatic logic [63:0] rand64;
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed;
    logic [3:0] ks;
    ks = saturate(cfg_key_bytes);
    send_access(ACT_WRITE, '1, ks, 0, 8, '1, 8'hFF);
    send_access(ACT_READ, '1, ks, 0, 8, 0, 0);
    send_access(ACT_INSERT, 64'h0, ks, 0, 0, 0, 0);
    send_access(ACT_INSERT, 64'h0, ks, 2, 3, 64'h00AABBCC, 8'h05);
    send_access(ACT_UPDATE, 64'h0, ks, 2, 3, 64'h00AABBCC, 8'h07);
    send_access(ACT_READ, 64'h0, ks, 1, 8, 0, 0);
    send_access(ACT_READ, 64'h0, ks, 8, 8, 0, 0);
    send_access(ACT_UPDATE, 64'h55, ks, 0, 1, 1, 1);
    send_access(ACT_WRITE, 64'h1, ks, 5, 4, '1, 8'hFF);
    send_access(ACT_WRITE, 64'h1, ks, 8, 0, 0, 0);
    send_access(ACT_READ, 64'h1, 4'd3, 0, 8, 0, 0);
    send_access(ACT_NOP, 64'h1, ks, 0, 8, 0, 0);
    send_access(3'd6, 64'h1, ks, 0, 8, 0, 0);
    send_access(3'd7, '1, 4'd15, 15, 15, '1, 8'hFF);
    send_access(ACT_REMOVE, 64'h0, ks, 0, 8, 0, 0);
    send_access(ACT_REMOVE, 64'h0, ks, 0, 8, 0, 0);
    send_access(ACT_READ, '1, ks, 15, 15, 0, 0);
  endtask

  // Fills the table to overflow, then removes the keys that it inserted.
  task automatic test_full_table;
    logic [3:0] ks;
    ks = saturate(cfg_key_bytes);
    for (int i = 0; i < TableEntries + 2; i++)
      send_access(i[0] ? ACT_INSERT : ACT_WRITE, 64'(i + 16), ks, 0, 8, rand64(), 8'hFF);
    for (int i = 0; i < TableEntries + 2; i++)
      send_access(ACT_REMOVE, 64'(i + 16), ks, 0, 0, 0, 0);
  endtask

  // Random accesses over a small key space so that hits are common.
  task automatic test_random(input int n);
    logic [3:0] ks, klen;
    logic [63:0] key;
    ks = saturate(cfg_key_bytes);
    for (int i = 0; i < n; i++) begin
      key = $urandom_range(0, 9) == 0 ? rand64() : 64'($urandom_range(0, 11))
            | (rand64() & ~byte_lanes(ks));
      klen = $urandom_range(0, 9) == 0 ? 4'($urandom_range(0, 15)) : ks;
      send_access(3'($urandom_range(0, 7)), key, klen,
                  $urandom_range(0, 4) == 0 ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(0, 8)),
                  $urandom_range(0, 4) == 0 ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(0, 8)),
                  rand64(), 8'($urandom));
    end
  endtask

  // Receiver holds off long while items keep coming.
  task automatic test_backpressure;
    long_hold = 1;
    test_random(20);
  endtask

  initial begin
    rst <= 1;
    psel <= 0; penable <= 0; pwrite <= 0; paddr <= 0; pwdata <= 0;
    in_valid <= 0; action <= 0; lookup_key <= 0; key_len <= 0;
    byte_offset <= 0; byte_count <= 0; write_data <= 0; byte_mask <= 0;
    cfg_key_bytes = 8;
    cfg_value_bytes = 8;
    for (int i = 0; i < TableEntries; i++) begin
      shadow_valid[i] = 0;
      shadow_key[i] = 0;
      shadow_value[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_backpressure();
    test_random(100);
    write_register(REG_KEY_BYTES, 4'd1);
    write_register(REG_VALUE_BYTES, 4'd1);
    test_directed();
    test_random(90);
    write_register(REG_KEY_BYTES, 4'd3);
    write_register(REG_VALUE_BYTES, 4'd5);
    test_random(90);
    write_register(REG_KEY_BYTES, 4'd0);
    write_register(REG_VALUE_BYTES, 4'd15);
    test_random(60);
    write_register(REG_KEY_BYTES, 4'd8);
    write_register(REG_VALUE_BYTES, 4'd8);
    idle_enable = 0;
    test_random(80);
    drain();
    if (errors == 0) $display("[keyed_map_access_engine_top] OK");
    else $display("[keyed_map_access_engine_top] ERROR");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+design
design/kmae_pkg.sv
design/kmae_ctrl.sv
design/kmae_datapath.sv
design/keyed_map_access_engine_top.sv
dv/tb.sv
